// ----- hw/rtl/shbs_pkg.sv -----
// Shared types and constants for the SHA-256 byte stream hasher.
// Holds the beat payload structs, the queue word type and the SHA-256 tables.
// No dependencies.
package shbs_pkg;

  // Default depth of the word queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Word slots of the 64-bit bit length inside the final block
  localparam logic [3:0] LEN_HI_SLOT = 4'd14;
  localparam logic [3:0] LEN_LO_SLOT = 4'd15;

  // First padding byte
  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Input beat
  typedef struct packed {
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_item_t;

  // Output beat
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // Queue entry: one big-endian message word; last marks word 15 of the final block
  typedef struct packed {
    logic [31:0] data;
    logic        last;
  } word_t;

  localparam logic [31:0] ROUND_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_HASH [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

endpackage

// ----- hw/rtl/shbs_front.sv -----
// Front end: takes byte beats, packs them into big-endian words and generates
// the padding and length words at end of message. Depends on shbs_pkg.
module shbs_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  shbs_pkg::in_item_t in_data,
  output logic               push,
  output shbs_pkg::word_t    push_word,
  input  logic               q_full
);

  typedef enum logic [1:0] {
    F_TAKE = 2'b01,
    F_PAD  = 2'b10
  } front_state_t;

  front_state_t state;
  logic [5:0]   fill;       // bytes in the current block
  logic [31:0]  acc;        // partial word, high bytes valid
  logic [63:0]  total_bits;
  logic [31:0]  pad_word;   // word holding the 0x80 marker
  logic [3:0]   slot;       // word slot of the next padding word
  logic         first;
  logic         two_blk;    // another block follows the current padding block
  logic [63:0]  len_bits;

  logic         take;
  logic         word_done;
  logic [31:0]  acc_byte;
  logic [31:0]  acc_b;
  logic [5:0]   fill_b;
  logic [63:0]  total_b;
  logic [31:0]  pad_first;
  logic [31:0]  pad_out;
  logic         pad_last;

  // keep bytes above pos, place b at pos, clear the rest
  function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] pos,
                                           input logic [7:0] b);
    logic [31:0] r;
    case (pos)
      2'd0: r = {b, 24'h0};
      2'd1: r = {w[31:24], b, 16'h0};
      2'd2: r = {w[31:16], b, 8'h0};
      default: r = {w[31:8], b};
    endcase
    return r;
  endfunction

  assign in_stall = (state != F_TAKE) || q_full;
  assign take     = in_valid && !in_stall;

  // byte insertion
  assign acc_byte  = put_byte(acc, fill[1:0], in_data.msg_byte);
  assign word_done = in_data.has_byte && (fill[1:0] == 2'd3);
  assign acc_b     = in_data.has_byte ? acc_byte : acc;
  assign fill_b    = in_data.has_byte ? fill + 6'd1 : fill;
  assign total_b   = in_data.has_byte ? total_bits + 64'd8 : total_bits;
  assign pad_first = put_byte(acc_b, fill_b[1:0], shbs_pkg::PAD_BYTE);

  // padding word selection
  assign pad_last = !two_blk && (slot == shbs_pkg::LEN_LO_SLOT);
  always_comb begin
    if (first) begin
      pad_out = pad_word;
    end else if (!two_blk && (slot == shbs_pkg::LEN_HI_SLOT)) begin
      pad_out = len_bits[63:32];
    end else if (pad_last) begin
      pad_out = len_bits[31:0];
    end else begin
      pad_out = 32'h0;
    end
  end

  // queue push
  always_comb begin
    if (state == F_PAD) begin
      push           = !q_full;
      push_word.data = pad_out;
      push_word.last = pad_last;
    end else begin
      push           = take && word_done;
      push_word.data = acc_byte;
      push_word.last = 1'b0;
    end
  end

  // control and data registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_TAKE;
      fill       <= '0;
      total_bits <= '0;
      slot       <= '0;
      first      <= 1'b0;
      two_blk    <= 1'b0;
    end else begin
      case (state)
        F_TAKE: begin
          if (take) begin
            acc <= acc_b;
            if (in_data.end_of_message) begin
              fill       <= '0;
              total_bits <= '0;
              pad_word   <= pad_first;
              slot       <= fill_b[5:2];
              first      <= 1'b1;
              two_blk    <= (fill_b[5:2] >= shbs_pkg::LEN_HI_SLOT);
              len_bits   <= total_b;
              state      <= F_PAD;
            end else begin
              fill       <= fill_b;
              total_bits <= total_b;
            end
          end
        end
        F_PAD: begin
          if (!q_full) begin
            slot  <= slot + 4'd1;
            first <= 1'b0;
            if (slot == shbs_pkg::LEN_LO_SLOT) begin
              if (two_blk) begin
                two_blk <= 1'b0;
              end else begin
                state <= F_TAKE;
              end
            end
          end
        end
        default: state <= F_TAKE;
      endcase
    end
  end

  // an end-of-message beat always starts padding
  a_end_pads: assert property (@(posedge clk) disable iff (rst)
    (take && in_data.end_of_message) |=> (state == F_PAD))
    else $error("end of message did not start padding");

endmodule

// ----- hw/rtl/shbs_queue.sv -----
// Short word queue between the front end and the compression back end.
// Register storage, read at the head. Depends on shbs_pkg.
module shbs_queue #(
  parameter int DEPTH = shbs_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  shbs_pkg::word_t push_word,
  output logic            full,
  input  logic            pop,
  output shbs_pkg::word_t pop_word,
  output logic            empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  shbs_pkg::word_t   mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_word = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue pop while empty");

endmodule

// ----- hw/rtl/shbs_back.sv -----
// Back end: loads 16 words per block, runs 64 SHA-256 rounds at one per cycle,
// folds the result into the hash and emits the digest. Depends on shbs_pkg.
module shbs_back (
  input  logic                clk,
  input  logic                rst,
  output logic                pop,
  input  shbs_pkg::word_t     pop_word,
  input  logic                q_empty,
  output logic                out_valid,
  input  logic                out_stall,
  output shbs_pkg::out_item_t out_data
);

  typedef enum logic [3:0] {
    B_LOAD  = 4'b0001,
    B_ROUND = 4'b0010,
    B_ADD   = 4'b0100,
    B_OUT   = 4'b1000
  } back_state_t;

  back_state_t state;
  logic [3:0]  wcnt;
  logic [5:0]  rnd;
  logic        last_blk;
  logic [2:0]  oidx;
  logic [31:0] w [16];
  logic [31:0] v [8];
  logic [31:0] h [8];

  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] w_new;

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] sml_s0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] sml_s1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'h0, x[31:10]};
  endfunction

  // round datapath
  assign t1 = v[7] + big_s1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
            + shbs_pkg::ROUND_K[rnd] + w[0];
  assign t2 = big_s0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  // message schedule
  assign w_new = sml_s1(w[14]) + w[9] + sml_s0(w[1]) + w[0];

  assign pop       = (state == B_LOAD) && !q_empty;
  assign out_valid = (state == B_OUT);

  // digest beat comes straight from the hash registers
  assign out_data.digest_word = h[oidx];
  assign out_data.word_index  = oidx;
  assign out_data.last_word   = (oidx == 3'd7);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_LOAD;
      wcnt  <= '0;
      rnd   <= '0;
      oidx  <= '0;
      for (int i = 0; i < 8; i++) begin
        h[i] <= shbs_pkg::INIT_HASH[i];
      end
    end else begin
      case (state)
        B_LOAD: begin
          if (pop) begin
            for (int i = 0; i < 15; i++) begin
              w[i] <= w[i+1];
            end
            w[15] <= pop_word.data;
            wcnt  <= wcnt + 4'd1;
            if (wcnt == 4'd15) begin
              last_blk <= pop_word.last;
              rnd      <= '0;
              for (int i = 0; i < 8; i++) begin
                v[i] <= h[i];
              end
              state <= B_ROUND;
            end
          end
        end
        B_ROUND: begin
          v[0] <= t1 + t2;
          v[1] <= v[0];
          v[2] <= v[1];
          v[3] <= v[2];
          v[4] <= v[3] + t1;
          v[5] <= v[4];
          v[6] <= v[5];
          v[7] <= v[6];
          for (int i = 0; i < 15; i++) begin
            w[i] <= w[i+1];
          end
          w[15] <= w_new;
          rnd   <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            state <= B_ADD;
          end
        end
        B_ADD: begin
          for (int i = 0; i < 8; i++) begin
            h[i] <= h[i] + v[i];
          end
          oidx  <= '0;
          state <= last_blk ? B_OUT : B_LOAD;
        end
        B_OUT: begin
          if (!out_stall) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              for (int i = 0; i < 8; i++) begin
                h[i] <= shbs_pkg::INIT_HASH[i];
              end
              state <= B_LOAD;
            end
          end
        end
        default: state <= B_LOAD;
      endcase
    end
  end

  // hash restarts after the last digest beat
  a_hash_restart: assert property (@(posedge clk) disable iff (rst)
    (state == B_OUT && !out_stall && oidx == 3'd7) |=> (h[0] == shbs_pkg::INIT_HASH[0]))
    else $error("hash not restarted after digest");
  // rounds only start on a full block
  a_full_block: assert property (@(posedge clk) disable iff (rst)
    (state == B_ROUND) |-> (wcnt == 4'd0))
    else $error("rounds running on a partial block");

endmodule

// ----- hw/rtl/sha256_byte_stream_hasher_core.sv -----
// SHA-256 over a byte stream: at most one byte per input beat, digest as eight words.
// A byte beat is taken while the front end is not padding and the default 4-word queue has room.
// Per block the back end pops 16 words, runs 64 rounds and does one hash update, and pops no
// new words until that update is done; the end of a message may need one or two padding blocks.
// Reset (sync, active high): hash to initial values, counts to zero, queue empty.
module sha256_byte_stream_hasher_core #(
  parameter int QUEUE_DEPTH = shbs_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  shbs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output shbs_pkg::out_item_t out_data
);

  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;
  shbs_pkg::word_t push_word;
  shbs_pkg::word_t pop_word;

  shbs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_word (push_word),
    .q_full    (q_full)
  );

  shbs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .full      (q_full),
    .pop       (pop),
    .pop_word  (pop_word),
    .empty     (q_empty)
  );

  shbs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop       (pop),
    .pop_word  (pop_word),
    .q_empty   (q_empty),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for sha256_byte_stream_hasher_core: byte beats in, digest beats out.
// A small SHA-256 predictor inside a scoreboard class checks each digest word in order.
// Depends on shbs_pkg (beat payload structs) and the core RTL only.
module tb;

  localparam int PHASE_ITEMS  = 70;    // message beats per idling phase
  localparam int HOLD_CYCLES  = 500;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 200;   // stray-beat watch after the last owed digest
  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [31:0] SHA_ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Lengths around the padding boundary and the block boundary
  localparam int EDGE_LENS [6] = '{55, 56, 57, 63, 64, 65};

  // Scoreboard: running SHA-256 state plus the digest words still owed by the core
  class digest_predictor;
    logic [31:0] chain [8];
    logic [7:0]  block [64];
    int unsigned fill;
    logic [63:0] bit_len;
    shbs_pkg::out_item_t pending_digest [$];
    int          errors;
    int          words_checked;
    int          digests;

    function new();
      errors = 0;
      words_checked = 0;
      digests = 0;
      foreach (block[k]) block[k] = 8'h00;
      restart();
    endfunction

    function void restart();
      foreach (chain[k]) chain[k] = SHA_IV[k];
      fill = 0;
      bit_len = '0;
    endfunction

    function logic [31:0] rotr(logic [31:0] v, int unsigned n);
      return (v >> n) | (v << (32 - n));
    endfunction

    // 64-round compression of the current block into the chain
    function void compress();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int r = 0; r < 16; r++)
        w[r] = {block[4*r], block[4*r+1], block[4*r+2], block[4*r+3]};
      for (int r = 16; r < 64; r++)
        w[r] = (rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7] +
               (rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
      for (int r = 0; r < 64; r++) begin
        t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g)) +
             SHA_ROUND_CONST[r] + w[r];
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1;
        d = c; c = b; b = a; a = t1 + t2;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
      chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    // Accepted input beat: absorb the byte, and on end of message pad and queue the digest
    function void take_beat(shbs_pkg::in_item_t beat);
      int unsigned pos;
      shbs_pkg::out_item_t word;
      if (beat.has_byte) begin
        block[fill] = beat.msg_byte;
        fill++;
        bit_len += 64'd8;
        if (fill == 64) begin
          compress();
          fill = 0;
        end
      end
      if (!beat.end_of_message) return;
      pos = fill;
      block[pos] = PAD_MARK;
      pos++;
      // no room for the length: spill into a second block
      if (pos > 56) begin
        while (pos < 64) begin
          block[pos] = 8'h00;
          pos++;
        end
        compress();
        pos = 0;
      end
      while (pos < 56) begin
        block[pos] = 8'h00;
        pos++;
      end
      for (int k = 0; k < 8; k++) block[56+k] = bit_len[63-8*k -: 8];
      compress();
      for (int k = 0; k < 8; k++) begin
        word.digest_word = chain[k];
        word.word_index  = 3'(k);
        word.last_word   = (k == 7);
        pending_digest.push_back(word);
      end
      digests++;
      restart();
    endfunction

    // Accepted output beat: compare with the oldest owed digest word
    function void check_beat(shbs_pkg::out_item_t got);
      shbs_pkg::out_item_t want;
      if (pending_digest.size() == 0) begin
        $error("unexpected digest beat: word_index %0d digest_word %h",
               got.word_index, got.digest_word);
        errors++;
        return;
      end
      want = pending_digest.pop_front();
      words_checked++;
      if (got.digest_word !== want.digest_word) begin
        $error("digest_word: expected %h, got %h", want.digest_word, got.digest_word);
        errors++;
      end
      if (got.word_index !== want.word_index) begin
        $error("word_index: expected %0d, got %0d", want.word_index, got.word_index);
        errors++;
      end
      if (got.last_word !== want.last_word) begin
        $error("last_word: expected %0b, got %0b", want.last_word, got.last_word);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  shbs_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  shbs_pkg::out_item_t out_data;

  digest_predictor sb;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_trigger   = 0;
  int hold_taken     = 0;
  int hold_left      = 0;
  int items_sent     = 0;
  int messages_sent  = 0;
  int longest_msg    = 0;

  sha256_byte_stream_hasher_core dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Beat monitor on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_beat(out_data);
      if (in_valid && !in_stall) sb.take_beat(in_data);
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_trigger != hold_taken) begin
        hold_taken = hold_trigger;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  function automatic shbs_pkg::in_item_t mk_beat(logic [7:0] value, logic has, logic eom);
    shbs_pkg::in_item_t beat;
    beat.msg_byte       = value;
    beat.has_byte       = has;
    beat.end_of_message = eom;
    return beat;
  endfunction

  // Offer one beat after a random gap and hold it until accepted
  task automatic send_beat(input shbs_pkg::in_item_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (beat.has_byte || beat.end_of_message) items_sent++;
  endtask

  task automatic send_noise();
    send_beat(mk_beat(8'($urandom_range(255)), 1'b0, 1'b0));
  endtask

  // Random-content message; end rides on the last byte or comes as its own beat
  task automatic send_message(input int len, input bit end_alone, input int noise_pct);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < noise_pct) send_noise();
      send_beat(mk_beat(8'($urandom_range(255)), 1'b1, (i == len - 1) && !end_alone));
    end
    if (len == 0 || end_alone) send_beat(mk_beat(8'($urandom_range(255)), 1'b0, 1'b1));
    messages_sent++;
    if (len > longest_msg) longest_msg = len;
  endtask

  // Main sequence
  initial begin
    int len;
    sb = new();
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase

      if (phase == 0) begin
        // empty message: end marker only, its byte ignored
        send_beat(mk_beat(8'hff, 1'b0, 1'b1));
        // "abc", end on the last byte
        send_beat(mk_beat(8'h61, 1'b1, 1'b0));
        send_beat(mk_beat(8'h62, 1'b1, 1'b0));
        send_beat(mk_beat(8'h63, 1'b1, 1'b1));
        // one zero byte with end
        send_beat(mk_beat(8'h00, 1'b1, 1'b1));
        // all-ones byte, an ignored beat, then a separate end marker
        send_beat(mk_beat(8'hff, 1'b1, 1'b0));
        send_beat(mk_beat(8'h5a, 1'b0, 1'b0));
        send_beat(mk_beat(8'h00, 1'b0, 1'b1));
        // lone ignored beat between messages
        send_beat(mk_beat(8'ha5, 1'b0, 1'b0));
        send_beat(mk_beat(8'h80, 1'b1, 1'b0));
        send_beat(mk_beat(8'h7f, 1'b1, 1'b1));
        // receiver holds off while two messages go in, so the core backs up
        hold_trigger++;
        send_message(4, 1'b0, 0);
        send_message(64, 1'b1, 0);
      end

      while (items_sent < (phase + 1) * PHASE_ITEMS) begin
        if ($urandom_range(9) < 2) len = EDGE_LENS[$urandom_range(5)];
        else len = $urandom_range(12);
        send_message(len, $urandom_range(1), 5);
        if ($urandom_range(9) == 0) send_noise();
      end
    end
    in_valid <= 1'b0;

    // drain owed digests, then watch for strays
    while (sb.pending_digest.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d messages (longest %0d bytes), %0d message beats, four idling phases",
             messages_sent, longest_msg, items_sent);
    $display("tb: %0d digests, %0d digest words checked", sb.digests, sb.words_checked);
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("tb: done, errors");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/shbs_pkg.sv
hw/rtl/shbs_front.sv
hw/rtl/shbs_queue.sv
hw/rtl/shbs_back.sv
hw/rtl/sha256_byte_stream_hasher_core.sv
tb/tb.sv
